// File: rtl/core/rdi_pkg.sv
// Shared types and constants for the radial distortion inverse core.
// No dependencies.
package rdi_pkg;

	localparam int MAX_ITERATIONS = 16;
	localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

	localparam logic signed [27:0] EST_MAX = 28'sd33554431;
	// ceil(2^36/9) and ceil(2^36/10): exact floor division for operands below 2^28
	localparam logic [63:0] START_RECIP_UP = 64'd7635497416;
	localparam logic [63:0] START_RECIP_DN = 64'd6871947674;

	localparam logic [23:0] RST_QUAD = 24'd983040;
	localparam logic [23:0] RST_QUART = 24'd6553600;
	localparam logic [15:0] RST_TOL = 16'd419;

	localparam logic [1:0] CFG_QUAD = 2'd0;
	localparam logic [1:0] CFG_QUART = 2'd1;
	localparam logic [1:0] CFG_TOL = 2'd2;

	typedef enum logic {MD_MUL, MD_DIV} md_op_t;

	typedef struct packed {
		logic   start;
		md_op_t op;
	} md_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} md_sts_t;

endpackage

// File: rtl/core/rdi_muldiv.sv
// Shared sequential unit: shift-add multiply and restoring divide, one bit a cycle.
// Depends on rdi_pkg.
module rdi_muldiv import rdi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  md_req_t     req,
	input  logic [63:0] opnd_a,
	input  logic [63:0] opnd_b,
	output md_sts_t     sts,
	output logic [63:0] result
);

	logic        busy_q;
	logic        done_q;
	md_op_t      op_q;
	logic [63:0] acc_q;
	logic [63:0] opa_q;
	logic [63:0] opb_q;
	logic [5:0]  cnt_q;
	logic [64:0] shifted;
	logic [64:0] trial;

	always_comb begin
		shifted = {acc_q, opa_q[63]};
		trial = shifted - {1'b0, opb_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q <= MD_MUL;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q <= req.op;
				cnt_q <= 6'd63;
			end else if (busy_q) begin
				case (op_q)
					MD_MUL: begin
						if (opb_q[63:1] == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					MD_DIV: begin
						cnt_q <= cnt_q - 6'd1;
						if (cnt_q == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					default: busy_q <= 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			opa_q <= opnd_a;
			opb_q <= opnd_b;
		end else if (busy_q) begin
			if (op_q == MD_MUL) begin
				if (opb_q[0]) acc_q <= acc_q + opa_q;
				opa_q <= {opa_q[62:0], 1'b0};
				opb_q <= {1'b0, opb_q[63:1]};
			end else begin
				if (!trial[64]) begin
					acc_q <= trial[63:0];
					opa_q <= {opa_q[62:0], 1'b1};
				end else begin
					acc_q <= shifted[63:0];
					opa_q <= {opa_q[62:0], 1'b0};
				end
			end
		end
	end

	assign sts = '{busy: busy_q, done: done_q};
	assign result = (op_q == MD_MUL) ? acc_q : opa_q;

endmodule

// File: rtl/core/radial_distortion_inverse_core.sv
// Top level: secant search for the undistorted lens radius.
// Depends on rdi_pkg and rdi_muldiv.
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_stall    distorted_radius
//  out      out  out_valid/out_stall  undistorted_radius, converged
//  cfg      in   cfg_we               cfg_index, cfg_data
//
// One beat at a time; every multiply and divide runs on the one bit-serial unit.
// Startup runs two reciprocal multiplies and the first distortion; each secant
// step then runs six multiplies and a divide. Reset restores coefficient and
// tolerance defaults. in_stall is high while busy; a finished result waits in
// the output register without blocking the next beat.
module radial_distortion_inverse_core import rdi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [23:0] distorted_radius,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] undistorted_radius,
	output logic        converged,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_R0, ST_R1, ST_DS, ST_DT, ST_DA, ST_DB, ST_DP,
		ST_CHECK, ST_NUM, ST_DIV, ST_OUT
	} state_t;

	state_t state_q;

	logic [23:0] quad_q;
	logic [23:0] quart_q;
	logic [15:0] tol_q;

	md_req_t     req_q;
	logic [63:0] opa_q;
	logic [63:0] opb_q;
	md_sts_t     sts;
	logic [63:0] res;

	logic [23:0]        rad_q;
	logic signed [25:0] r0_q;
	logic signed [25:0] r1_q;
	logic signed [33:0] d0_q;
	logic signed [33:0] d1_q;
	logic [34:0]        den_q;
	logic               neg_q;
	logic               sgn_q;
	logic [24:0]        m_q;
	logic [27:0]        s_q;
	logic [33:0]        t_q;
	logic [36:0]        f_q;
	logic               ret_q;
	logic [ITER_W-1:0]  iter_q;
	logic               conv_q;
	logic               out_valid_q;
	logic [23:0]        out_rad_q;
	logic               out_conv_q;

	logic signed [26:0] diff;
	logic [26:0]        diff_m;
	logic [24:0]        r1_m;
	logic [42:0]        fsum;
	logic [37:0]        fsat;
	logic [31:0]        psat;
	logic signed [33:0] dnew;
	logic [33:0]        dnew_m;
	logic signed [34:0] den;
	logic [34:0]        den_m;
	logic [25:0]        qsat;
	logic signed [27:0] rnext;
	logic signed [27:0] rclamp;
	logic [23:0]        rsat;
	logic [27:0]        rad10;
	logic [27:0]        rad9;

	rdi_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.opnd_a (opa_q),
		.opnd_b (opb_q),
		.sts    (sts),
		.result (res)
	);

	always_comb begin
		rad10 = {1'b0, distorted_radius, 3'b0} + {3'b0, distorted_radius, 1'b0};
		rad9 = {1'b0, rad_q, 3'b0} + {4'b0, rad_q};
		diff = {r1_q[25], r1_q} - {r0_q[25], r0_q};
		diff_m = diff[26] ? 27'(-diff) : diff;
		r1_m = r1_q[25] ? 25'(-r1_q) : r1_q[24:0];
		fsum = {6'b0, f_q} + {1'b0, res[57:16]};
		fsat = (fsum[42:38] != '0) ? '1 : fsum[37:0];
		psat = (res[62:54] != '0) ? '1 : res[53:22];
		dnew = sgn_q ? ({10'b0, rad_q} + {2'b0, psat}) : ({10'b0, rad_q} - {2'b0, psat});
		dnew_m = dnew[33] ? 34'(-dnew) : dnew;
		den = {dnew[33], dnew} - {d0_q[33], d0_q};
		den_m = den[34] ? 35'(-den) : den;
		// any step this large already lands past the estimate limit
		qsat = (res[63:26] != '0) ? '1 : res[25:0];
		rnext = neg_q ? ({{2{r1_q[25]}}, r1_q} + {2'b0, qsat})
		              : ({{2{r1_q[25]}}, r1_q} - {2'b0, qsat});
		if (rnext > EST_MAX) rclamp = EST_MAX;
		else if (rnext < -EST_MAX) rclamp = -EST_MAX;
		else rclamp = rnext;
		if (r1_q[25]) rsat = '0;
		else if (r1_q[24]) rsat = '1;
		else rsat = r1_q[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quad_q <= RST_QUAD;
			quart_q <= RST_QUART;
			tol_q <= RST_TOL;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_QUAD:  quad_q <= cfg_data;
				CFG_QUART: quart_q <= cfg_data;
				CFG_TOL:   tol_q <= cfg_data[15:0];
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_q <= '{start: 1'b0, op: MD_MUL};
			iter_q <= '0;
			ret_q <= 1'b0;
			conv_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req_q.start) req_q.start <= 1'b0;
			if (out_valid_q && !out_stall && state_q != ST_OUT) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						rad_q <= distorted_radius;
						iter_q <= '0;
						req_q <= '{start: 1'b1, op: MD_MUL};
						opa_q <= {36'b0, rad10};
						opb_q <= START_RECIP_UP;
						state_q <= ST_R0;
					end
				end
				ST_R0: begin
					if (sts.done) begin
						r0_q <= res[61:36];
						req_q <= '{start: 1'b1, op: MD_MUL};
						opa_q <= {36'b0, rad9};
						opb_q <= START_RECIP_DN;
						state_q <= ST_R1;
					end
				end
				ST_R1: begin
					if (sts.done) begin
						r1_q <= res[61:36];
						ret_q <= 1'b0;
						sgn_q <= r0_q[25];
						m_q <= r0_q[24:0];
						req_q <= '{start: 1'b1, op: MD_MUL};
						opa_q <= {39'b0, r0_q[24:0]};
						opb_q <= {39'b0, r0_q[24:0]};
						state_q <= ST_DS;
					end
				end
				ST_DS: begin
					if (sts.done) begin
						s_q <= res[49:22];
						req_q <= '{start: 1'b1, op: MD_MUL};
						opa_q <= {36'b0, res[49:22]};
						opb_q <= {36'b0, res[49:22]};
						state_q <= ST_DT;
					end
				end
				ST_DT: begin
					if (sts.done) begin
						t_q <= res[55:22];
						req_q <= '{start: 1'b1, op: MD_MUL};
						opa_q <= {40'b0, quad_q};
						opb_q <= {36'b0, s_q};
						state_q <= ST_DA;
					end
				end
				ST_DA: begin
					if (sts.done) begin
						f_q <= 37'(res[51:16]) + 37'(1 << 22);
						req_q <= '{start: 1'b1, op: MD_MUL};
						opa_q <= {40'b0, quart_q};
						opb_q <= {30'b0, t_q};
						state_q <= ST_DB;
					end
				end
				ST_DB: begin
					if (sts.done) begin
						req_q <= '{start: 1'b1, op: MD_MUL};
						opa_q <= {26'b0, fsat};
						opb_q <= {39'b0, m_q};
						state_q <= ST_DP;
					end
				end
				ST_DP: begin
					if (sts.done) begin
						if (!ret_q) begin
							d0_q <= dnew;
							state_q <= ST_CHECK;
						end else begin
							d1_q <= dnew;
							den_q <= den_m;
							neg_q <= dnew[33] ^ diff[26] ^ den[34];
							if (den == '0) begin
								conv_q <= 1'b0;
								state_q <= ST_OUT;
							end else begin
								req_q <= '{start: 1'b1, op: MD_MUL};
								opa_q <= {30'b0, dnew_m};
								opb_q <= {37'b0, diff_m};
								state_q <= ST_NUM;
							end
						end
					end
				end
				ST_CHECK: begin
					if (diff_m <= {11'b0, tol_q}) begin
						conv_q <= 1'b1;
						state_q <= ST_OUT;
					end else if (iter_q == ITER_W'(MAX_ITERATIONS)) begin
						conv_q <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						ret_q <= 1'b1;
						sgn_q <= r1_q[25];
						m_q <= r1_m;
						req_q <= '{start: 1'b1, op: MD_MUL};
						opa_q <= {39'b0, r1_m};
						opb_q <= {39'b0, r1_m};
						state_q <= ST_DS;
					end
				end
				ST_NUM: begin
					if (sts.done) begin
						req_q <= '{start: 1'b1, op: MD_DIV};
						opa_q <= res;
						opb_q <= {29'b0, den_q};
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (sts.done) begin
						r0_q <= r1_q;
						r1_q <= rclamp[25:0];
						d0_q <= d1_q;
						iter_q <= iter_q + ITER_W'(1);
						state_q <= ST_CHECK;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_rad_q <= rsat;
						out_conv_q <= conv_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign undistorted_radius = out_rad_q;
	assign converged = out_conv_q;

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_q.start |-> !sts.busy)
		else $error("muldiv started while busy");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted beat did not stall input");

	a_iter_cap: assert property (@(posedge clk) disable iff (!arst_n)
		iter_q <= ITER_W'(MAX_ITERATIONS))
		else $error("iteration count past cap");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for radial_distortion_inverse_core: a built-in predictor
// of the secant search checks every result. Depends on rdi_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top import rdi_pkg::*;;

	localparam longint CYCLE_LIMIT = 25_000_000;
	localparam int RANDOM_PER_PHASE = 210;
	localparam int PHASES = 7;

	typedef struct {
		logic [23:0] radius;
		bit          known;
		logic [23:0] radius_exp;
		bit          conv_exp;
	} row_t;

	typedef struct {
		logic [23:0] radius;
		bit          conv;
	} solution_t;

	logic        clk, arst_n;
	logic        in_valid, in_stall;
	logic [23:0] distorted_radius;
	logic        out_valid, out_stall;
	logic [23:0] undistorted_radius;
	logic        converged;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	longint unsigned quad_q, quart_q, tol_q;
	solution_t solutions_due[$];
	int errors;
	longint cycles;
	bit send_quiet, recv_quiet;

	radial_distortion_inverse_core DUT (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	function automatic longint unsigned mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint clamp_est(longint v);
		if (v > 33554431) return 33554431;
		if (v < -33554431) return -33554431;
		return v;
	endfunction

	function automatic longint lens_distort(longint r);
		longint unsigned m, s, t, f, p;
		m = mag(r);
		s = (m * m) >> 22;
		t = (s * s) >> 22;
		f = (64'd1 << 22) + ((quad_q * s) >> 16) + ((quart_q * t) >> 16);
		if (f > 64'd274877906943) f = 64'd274877906943;
		p = (m * f) >> 22;
		if (p > 64'd4294967295) p = 64'd4294967295;
		return r < 0 ? -longint'(p) : longint'(p);
	endfunction

	function automatic solution_t solve_radius(logic [23:0] rad_in);
		longint radius, r0, r1, d0, d1, den, diff, res;
		longint unsigned q;
		bit neg;
		int iter;
		solution_t sol;
		radius = longint'(rad_in);
		r0 = clamp_est((radius * 10) / 9);
		r1 = clamp_est((radius * 9) / 10);
		d0 = radius - lens_distort(r0);
		iter = 0;
		sol.conv = 1'b1;
		while (mag(r1 - r0) > tol_q) begin
			if (iter >= MAX_ITERATIONS) begin
				sol.conv = 1'b0;
				break;
			end
			d1 = radius - lens_distort(r1);
			den = d1 - d0;
			if (den == 0) begin
				sol.conv = 1'b0;
				break;
			end
			diff = r1 - r0;
			q = (mag(d1) * mag(diff)) / mag(den);
			neg = ((d1 < 0) != (diff < 0)) != (den < 0);
			if (d1 == 0 || diff == 0) neg = 1'b0;
			r0 = r1;
			r1 = clamp_est(neg ? r1 + longint'(q) : r1 - longint'(q));
			d0 = d1;
			iter++;
		end
		res = r1;
		if (res < 0) res = 0;
		if (res > 16777215) res = 16777215;
		sol.radius = res[23:0];
		return sol;
	endfunction

	task automatic report(string what, logic [23:0] got, logic [23:0] want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int draw_wait(bit quiet);
		return quiet ? 0 : $urandom_range(0, 16);
	endfunction

	task automatic send_beat(logic [23:0] radius, bit known = 1'b0,
			logic [23:0] r_exp = 24'd0, bit c_exp = 1'b0);
		int gap;
		solution_t sol;
		gap = draw_wait(send_quiet);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		distorted_radius <= radius;
		do @(posedge clk); while (in_stall);
		sol = solve_radius(radius);
		if (known && (sol.radius !== r_exp || sol.conv !== c_exp))
			report("table row", sol.radius, r_exp);
		solutions_due = {solutions_due, sol};
	endtask

	task automatic write_cfg(logic [23:0] quad, logic [23:0] quart,
			logic [15:0] tol);
		in_valid <= 0;
		while (solutions_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= CFG_QUAD;
		cfg_data <= quad;
		@(posedge clk);
		cfg_index <= CFG_QUART;
		cfg_data <= quart;
		@(posedge clk);
		cfg_index <= CFG_TOL;
		cfg_data <= {8'd0, tol};
		@(posedge clk);
		cfg_we <= 0;
		quad_q = 64'(quad);
		quart_q = 64'(quart);
		tol_q = 64'(tol);
	endtask

	// receiver
	initial begin
		int n;
		solution_t want;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			n = draw_wait(recv_quiet);
			if (n > 0) begin
				out_stall <= 1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!out_valid);
			if (solutions_due.size() == 0) begin
				report("unexpected beat", undistorted_radius, 24'd0);
			end else begin
				want = solutions_due.pop_front();
				if (undistorted_radius !== want.radius)
					report("undistorted_radius", undistorted_radius, want.radius);
				if (converged !== want.conv)
					report("converged", {23'd0, converged}, {23'd0, want.conv});
			end
		end
	end

	initial begin
		row_t dir_rows[$];
		logic [23:0] r;
		int k;
		cycles = 0;
		errors = 0;
		send_quiet = 0;
		recv_quiet = 0;
		in_valid = 0;
		distorted_radius = 0;
		cfg_we = 0;
		cfg_index = CFG_QUAD;
		cfg_data = 0;
		quad_q = 64'(RST_QUAD);
		quart_q = 64'(RST_QUART);
		tol_q = 64'(RST_TOL);
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		dir_rows = '{
			'{24'd0, 1'b1, 24'd0, 1'b1},
			'{24'd1, 1'b0, 24'd0, 1'b0},
			'{24'd2, 1'b0, 24'd0, 1'b0},
			'{24'd16777215, 1'b0, 24'd0, 1'b0},
			'{24'd8388608, 1'b0, 24'd0, 1'b0},
			'{24'd4194304, 1'b0, 24'd0, 1'b0},
			'{24'd4194303, 1'b0, 24'd0, 1'b0},
			'{24'h555555, 1'b0, 24'd0, 1'b0},
			'{24'hAAAAAA, 1'b0, 24'd0, 1'b0},
			'{24'd1000, 1'b0, 24'd0, 1'b0},
			'{24'd100000, 1'b0, 24'd0, 1'b0},
			'{24'd2000000, 1'b0, 24'd0, 1'b0}
		};
		foreach (dir_rows[i])
			send_beat(dir_rows[i].radius, dir_rows[i].known,
				dir_rows[i].radius_exp, dir_rows[i].conv_exp);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: write_cfg(RST_QUAD, RST_QUART, RST_TOL);
				1: write_cfg(24'hFFFFFF, 24'hFFFFFF, 16'd1);
				2: write_cfg(24'd0, 24'd0, 16'hFFFF);
				3: write_cfg(24'd0, 24'hFFFFFF, 16'd1);
				4: write_cfg(24'hFFFFFF, 24'd0, 16'd419);
				default: write_cfg(24'($urandom_range(0, 24'hFFFFFF)),
					24'($urandom_range(0, 24'hFFFFFF)),
					16'($urandom_range(1, 16'hFFFF)));
			endcase
			send_beat(24'd0, 1'b1, 24'd0, 1'b1);
			send_beat(24'hFFFFFF);
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				if (i % 60 == 0) begin
					send_quiet = ($urandom_range(0, 3) == 0);
					recv_quiet = ($urandom_range(0, 3) == 0);
				end
				k = $urandom_range(0, 9);
				if (k < 4) r = 24'($urandom);
				else if (k < 8) r = 24'($urandom_range(0, 4194304));
				else if (k == 8) r = 24'($urandom_range(0, 64));
				else r = 24'hFFFFFF - 24'($urandom_range(0, 64));
				send_beat(r);
			end
		end
		in_valid <= 0;
		while (solutions_due.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule

// File: filelist.f
rtl/core/rdi_pkg.sv
rtl/core/rdi_muldiv.sv
rtl/core/radial_distortion_inverse_core.sv
tb/sv/tb_top.sv
